// ===== src/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and step functions for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int CHAN_W        = 8;
    localparam int HUE_FRAC_BITS = 6;
    localparam int SAT_BITS      = 16;
    localparam int HUE_SCALE     = 1 << HUE_FRAC_BITS;
    localparam int HUE_W         = $clog2(360 * HUE_SCALE);
    localparam int HUE_QUO_W     = $clog2(60 * HUE_SCALE + 1);
    // One quotient bit per divider stage; both lanes share the depth
    localparam int DIV_STAGES    = (HUE_QUO_W > SAT_BITS) ? HUE_QUO_W : SAT_BITS;
    localparam int NUM_W         = CHAN_W + DIV_STAGES;

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [HUE_W-1:0]    hue_out;
        logic [SAT_BITS-1:0] saturation_out;
        logic [CHAN_W-1:0]   value_out;
    } t_hsv_out;

    // Sector offset of the hue, in degrees
    typedef enum logic [1:0] {
        HB_0,
        HB_120,
        HB_240,
        HB_360
    } t_hue_base;

    typedef struct packed {
        t_hue_base         base;
        logic              neg;    // channel difference is negative
        logic              grey;   // delta is zero
        logic              black;  // largest channel is zero
        logic [CHAN_W-1:0] cmax;
    } t_side;

    // One restoring-division lane: partial remainder, and a word that
    // shifts dividend bits out and quotient bits in
    typedef struct packed {
        logic [CHAN_W-1:0]     rem;
        logic [DIV_STAGES-1:0] word;
        logic [CHAN_W-1:0]     divisor;
    } t_div_lane;

    typedef struct packed {
        t_div_lane hue;
        t_div_lane sat;
        t_side     side;
    } t_div_item;

    function automatic t_div_lane lane_step(input t_div_lane a);
        logic [CHAN_W:0] trial;
        logic [CHAN_W:0] diff;
        t_div_lane       r;
        trial = {a.rem, a.word[DIV_STAGES-1]};
        diff  = trial - {1'b0, a.divisor};
        r     = a;
        if (trial >= {1'b0, a.divisor}) begin
            r.rem  = diff[CHAN_W-1:0];
            r.word = {a.word[DIV_STAGES-2:0], 1'b1};
        end else begin
            r.rem  = trial[CHAN_W-1:0];
            r.word = {a.word[DIV_STAGES-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_div_item item_step(input t_div_item a);
        t_div_item r;
        r     = a;
        r.hue = lane_step(a.hue);
        r.sat = lane_step(a.sat);
        return r;
    endfunction

    function automatic logic [HUE_W-1:0] hue_base_val(input t_hue_base b);
        logic [HUE_W-1:0] v;
        case (b)
            HB_0:    v = '0;
            HB_120:  v = HUE_W'(120 * HUE_SCALE);
            HB_240:  v = HUE_W'(240 * HUE_SCALE);
            HB_360:  v = HUE_W'(360 * HUE_SCALE);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// Max, min, delta and sector selection; builds both divider dividends.
// ----------------------------------------------------------------------------
module rhc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rhc_pkg::t_pix_in    i_data,
    output logic                o_stall,
    output logic                o_valid,
    output rhc_pkg::t_div_item  o_item,
    input  logic                i_stall
);

    logic                      r_v;
    rhc_pkg::t_div_item        r_item;
    rhc_pkg::t_div_item        n_item;

    logic [rhc_pkg::CHAN_W-1:0] red;
    logic [rhc_pkg::CHAN_W-1:0] grn;
    logic [rhc_pkg::CHAN_W-1:0] blu;
    logic [rhc_pkg::CHAN_W-1:0] cmax;
    logic [rhc_pkg::CHAN_W-1:0] cmin;
    logic [rhc_pkg::CHAN_W-1:0] delta;
    logic [rhc_pkg::CHAN_W-1:0] mag;
    logic [rhc_pkg::NUM_W-1:0]  hue_num;
    logic [rhc_pkg::NUM_W-1:0]  sat_num;

    assign o_stall = r_v & i_stall;

    always_comb begin
        red  = i_data.red_in;
        grn  = i_data.green_in;
        blu  = i_data.blue_in;
        cmax = (red > grn) ? red : grn;
        if (blu > cmax) begin
            cmax = blu;
        end
        cmin = (red < grn) ? red : grn;
        if (blu < cmin) begin
            cmin = blu;
        end
        delta = cmax - cmin;

        n_item = '0;
        // red beats green on a tie, green beats blue
        if (red >= grn && red >= blu) begin
            if (grn >= blu) begin
                n_item.side.base = rhc_pkg::HB_0;
                n_item.side.neg  = 1'b0;
                mag              = grn - blu;
            end else begin
                n_item.side.base = rhc_pkg::HB_360;
                n_item.side.neg  = 1'b1;
                mag              = blu - grn;
            end
        end else if (grn >= blu) begin
            n_item.side.base = rhc_pkg::HB_120;
            n_item.side.neg  = (blu < red);
            mag              = (blu >= red) ? (blu - red) : (red - blu);
        end else begin
            n_item.side.base = rhc_pkg::HB_240;
            n_item.side.neg  = (red < grn);
            mag              = (red >= grn) ? (red - grn) : (grn - red);
        end
        n_item.side.grey  = (delta == '0);
        n_item.side.black = (cmax == '0);
        n_item.side.cmax  = cmax;

        hue_num = rhc_pkg::NUM_W'(mag) * rhc_pkg::NUM_W'(60 * rhc_pkg::HUE_SCALE);
        sat_num = (rhc_pkg::NUM_W'(delta) << rhc_pkg::SAT_BITS) - rhc_pkg::NUM_W'(delta);

        // Quotients fit DIV_STAGES bits, so the top byte already sits below the divisor
        n_item.hue.rem     = hue_num[rhc_pkg::NUM_W-1 -: rhc_pkg::CHAN_W];
        n_item.hue.word    = hue_num[rhc_pkg::DIV_STAGES-1:0];
        n_item.hue.divisor = delta;
        n_item.sat.rem     = sat_num[rhc_pkg::NUM_W-1 -: rhc_pkg::CHAN_W];
        n_item.sat.word    = sat_num[rhc_pkg::DIV_STAGES-1:0];
        n_item.sat.divisor = cmax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_v;
    assign o_item  = r_item;

endmodule

// ===== src/rhc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rhc_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rhc_div_pipe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rhc_pkg::t_div_item  i_item,
    output logic                o_stall,
    output logic                o_valid,
    output rhc_pkg::t_div_item  o_item,
    input  logic                i_stall
);

    localparam int N = rhc_pkg::DIV_STAGES;

    logic               r_v    [N];
    rhc_pkg::t_div_item r_item [N];
    rhc_pkg::t_div_item n_item [N];
    logic               v_in   [N];
    logic               stall  [N+1];

    assign stall[N] = i_stall;

    for (genvar k = 0; k < N; k++) begin : g_stage
        // a stage holds only when full and the stage after it holds
        assign stall[k] = r_v[k] & stall[k+1];

        if (k == 0) begin : g_first
            assign v_in[k]   = i_valid;
            assign n_item[k] = rhc_pkg::item_step(i_item);
        end else begin : g_next
            assign v_in[k]   = r_v[k-1];
            assign n_item[k] = rhc_pkg::item_step(r_item[k-1]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (!stall[k]) begin
                r_v[k] <= v_in[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!stall[k]) begin
                r_item[k] <= n_item[k];
            end
        end
    end

    assign o_stall = stall[0];
    assign o_valid = r_v[N-1];
    assign o_item  = r_item[N-1];

endmodule

// ===== src/rhc_back.sv =====
// ----------------------------------------------------------------------------
// rhc_back
// Hue assembly from sector offset and quotient, saturation forced to zero for black; output register.
// ----------------------------------------------------------------------------
module rhc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rhc_pkg::t_div_item  i_item,
    output logic                o_stall,
    output logic                o_valid,
    output rhc_pkg::t_hsv_out   o_data,
    input  logic                i_stall
);

    logic                        r_v;
    rhc_pkg::t_hsv_out           r_data;
    rhc_pkg::t_hsv_out           n_data;
    logic [rhc_pkg::HUE_W-1:0]   base;
    logic [rhc_pkg::HUE_W-1:0]   quo;
    logic [rhc_pkg::HUE_W-1:0]   rnd;

    assign o_stall = r_v & i_stall;

    always_comb begin
        base = rhc_pkg::hue_base_val(i_item.side.base);
        quo  = rhc_pkg::HUE_W'(i_item.hue.word);
        rnd  = rhc_pkg::HUE_W'(i_item.hue.rem != '0);

        // negative difference: floor of a negative quotient is minus the ceiling
        if (i_item.side.grey) begin
            n_data.hue_out = '0;
        end else if (i_item.side.neg) begin
            n_data.hue_out = base - quo - rnd;
        end else begin
            n_data.hue_out = base + quo;
        end

        if (i_item.side.black) begin
            n_data.saturation_out = '0;
        end else begin
            n_data.saturation_out = i_item.sat.word[rhc_pkg::SAT_BITS-1:0];
        end

        n_data.value_out = i_item.side.cmax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v;
    assign o_data  = r_data;

endmodule

// ===== src/rgb_to_hsv_converter.sv =====
// Pipeline: a front register, DIV_STAGES divider stages that each take one
//   quotient bit, and an output register.
// Throughput: one beat per cycle when not stalled; every stage holds only
//   when full and the stage after it holds, so bubbles close up under a stall.
// Reset: synchronous, active low; clears the valid bits of every stage.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Fixed-point RGB to HSV conversion of an 8-bit pixel stream.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    input  rhc_pkg::t_pix_in   i_data,
    output logic               o_stall,
    // output channel
    output logic               o_valid,
    output rhc_pkg::t_hsv_out  o_data,
    input  logic               i_stall
);

    // Front stage -> divider
    logic               front_valid;
    rhc_pkg::t_div_item front_item;
    logic               div_stall;

    // Divider -> back stage
    logic               div_valid;
    rhc_pkg::t_div_item div_item;
    logic               back_stall;

    // Stage 1: find max and min, pick the sector (red over green over blue
    // on a tie), and form the two dividends:
    //   hue: 60 * 2^HUE_FRAC_BITS * |channel difference| over delta
    //   sat: delta * (2^SAT_BITS - 1) over the largest channel
    rhc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_stall (div_stall)
    );

    // Stages 2 .. DIV_STAGES+1: both quotients advance one bit per stage in
    // lock-step; the sector and special-case flags ride alongside.
    rhc_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_item  (front_item),
        .o_stall (div_stall),
        .o_valid (div_valid),
        .o_item  (div_item),
        .i_stall (back_stall)
    );

    // Last stage: add or subtract the hue quotient from the sector offset
    // (rounding towards minus infinity via the remainder), force hue to zero
    // for grey and saturation to zero for black, and hold the output beat.
    rhc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_item  (div_item),
        .o_stall (back_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB to HSV converter. Pixels are pushed in on
// a valid/stall channel, each accepted beat is turned into an expected
// hue/saturation/value triple by an integer model held here, and every
// output beat is compared field by field, in order, against the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int    CLK_HALF    = 5;
    localparam int    RST_CYCLES  = 9;
    localparam int    PIPE_DEPTH  = rhc_pkg::DIV_STAGES + 2;
    localparam int    HOLD_CYCLES = 150;
    localparam int    CYCLE_LIMIT = 300000;
    localparam int    MAX_REPORTS = 10;
    localparam longint SAT_FULL   = (longint'(1) << rhc_pkg::SAT_BITS) - 1;
    localparam longint HUE_ONE    = longint'(1) << rhc_pkg::HUE_FRAC_BITS;

    // Sector offsets in whole degrees
    localparam longint DEG_GREEN  = 120;
    localparam longint DEG_BLUE   = 240;
    localparam longint DEG_WRAP   = 360;
    localparam longint DEG_SPAN   = 60;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    rhc_pkg::t_pix_in  i_data  = '0;
    logic              o_stall;
    logic              o_valid;
    rhc_pkg::t_hsv_out o_data;
    logic              i_stall = 1'b0;

    // Expected triples, oldest first
    rhc_pkg::t_hsv_out hsv_due[$];

    int  beats_in       = 0;
    int  beats_out      = 0;
    int  mismatch_count = 0;
    int  input_stalls   = 0;
    int  cycle_count    = 0;

    // Idling controls for each side; the long hold-off is asked for by a
    // test and then counted down by the stall process alone
    bit  tx_idle_en   = 1'b0;
    bit  rx_idle_en   = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left    = 0;
    int  rx_burst     = 0;

    rgb_to_hsv_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Give up well past the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, hsv_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Integer HSV model: value is the top channel, saturation the floored
    // span/top ratio at full scale, hue one exact floored quotient per sector.
    // Red wins ties over green, green over blue.
    // ------------------------------------------------------------------------
    function automatic rhc_pkg::t_hsv_out hsv_of(input rhc_pkg::t_pix_in px);
        longint            r, g, b, top, bot, span, base, up, down, num;
        rhc_pkg::t_hsv_out res;
        r    = px.red_in;
        g    = px.green_in;
        b    = px.blue_in;
        top  = (r > g) ? r : g;
        top  = (b > top) ? b : top;
        bot  = (r < g) ? r : g;
        bot  = (b < bot) ? b : bot;
        span = top - bot;
        up   = 0;
        down = 0;
        res.value_out      = top[rhc_pkg::CHAN_W-1:0];
        res.saturation_out = (top == 0) ? '0 :
                             rhc_pkg::SAT_BITS'((span * SAT_FULL) / top);
        if (span == 0) begin
            res.hue_out = '0;
        end else begin
            if (top == r) begin
                // Red sector: a negative difference wraps round by a full turn
                if (g >= b) begin
                    base = 0;
                    up   = g - b;
                end else begin
                    base = DEG_WRAP;
                    down = b - g;
                end
            end else if (top == g) begin
                base = DEG_GREEN;
                if (b >= r) up = b - r;
                else        down = r - b;
            end else begin
                base = DEG_BLUE;
                if (r >= g) up = r - g;
                else        down = g - r;
            end
            num = base * HUE_ONE * span + DEG_SPAN * HUE_ONE * (up - down);
            res.hue_out = rhc_pkg::HUE_W'(num / span);
        end
        return res;
    endfunction

    function automatic rhc_pkg::t_pix_in rgb(input int r, input int g, input int b);
        rhc_pkg::t_pix_in px;
        px.red_in   = r[rhc_pkg::CHAN_W-1:0];
        px.green_in = g[rhc_pkg::CHAN_W-1:0];
        px.blue_in  = b[rhc_pkg::CHAN_W-1:0];
        return px;
    endfunction

    // Mostly uniform colours, with a share of greys, tied maxima and near-black
    function automatic rhc_pkg::t_pix_in random_pixel();
        int               kind, v, w;
        rhc_pkg::t_pix_in px;
        kind = $urandom_range(0, 9);
        v    = $urandom_range(0, 255);
        w    = $urandom_range(0, 255);
        case (kind)
            0: px = rgb(v, v, v);
            1: begin
                case ($urandom_range(0, 2))
                    0:       px = rgb(v, v, w);
                    1:       px = rgb(w, v, v);
                    default: px = rgb(v, w, v);
                endcase
            end
            2: px = rgb($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            3: px = rgb(v, (v + $urandom_range(0, 2)) % 256, $urandom_range(0, 255));
            default: px = rgb(v, w, $urandom_range(0, 255));
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Send one pixel beat: optionally idle for a burst first, then hold the
    // beat until the block takes it, and queue its expected triple.
    // ------------------------------------------------------------------------
    task automatic send_pixel(input rhc_pkg::t_pix_in px);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hsv_due.push_back(hsv_of(px));
        beats_in++;
    endtask

    // Drop valid before returning so no beat is taken twice
    task automatic drop_valid();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (hsv_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall bursts, or the long hold-off when asked
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            i_stall     <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall  <= 1'b1;
        end else if (rx_burst != 0) begin
            rx_burst = rx_burst - 1;
            i_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            rx_burst = $urandom_range(1, 8) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every output beat against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        rhc_pkg::t_hsv_out want;
        if (i_rst_n) begin
            if (i_valid && o_stall) input_stalls++;
            if (o_valid && !i_stall) begin
                beats_out++;
                if (hsv_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result hue=%0d sat=%0d val=%0d",
                                 $realtime, o_data.hue_out, o_data.saturation_out,
                                 o_data.value_out);
                end else begin
                    want = hsv_due.pop_front();
                    if (o_data.hue_out !== want.hue_out ||
                        o_data.saturation_out !== want.saturation_out ||
                        o_data.value_out !== want.value_out) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t: result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     $realtime, beats_out, want.hue_out,
                                     want.saturation_out, want.value_out,
                                     o_data.hue_out, o_data.saturation_out,
                                     o_data.value_out);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corners: black, white, greys, primaries, every tie between top
    // channels, the red-sector wrap and tiny spans
    task automatic test_corner_colours();
        send_pixel(rgb(0, 0, 0));
        send_pixel(rgb(255, 255, 255));
        send_pixel(rgb(128, 128, 128));
        send_pixel(rgb(1, 1, 1));
        send_pixel(rgb(255, 0, 0));
        send_pixel(rgb(0, 255, 0));
        send_pixel(rgb(0, 0, 255));
        send_pixel(rgb(255, 255, 0));
        send_pixel(rgb(0, 255, 255));
        send_pixel(rgb(255, 0, 255));
        send_pixel(rgb(255, 0, 1));
        send_pixel(rgb(255, 1, 0));
        send_pixel(rgb(0, 1, 255));
        send_pixel(rgb(1, 0, 255));
        send_pixel(rgb(1, 255, 0));
        send_pixel(rgb(0, 255, 1));
        send_pixel(rgb(1, 0, 0));
        send_pixel(rgb(0, 0, 1));
        send_pixel(rgb(255, 254, 254));
        send_pixel(rgb(254, 255, 255));
        send_pixel(rgb(170, 85, 0));
        send_pixel(rgb(85, 170, 255));
        drop_valid();
    endtask

    // Bulk random colours with idling on both sides
    task automatic test_random_stream(input int count);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (count) send_pixel(random_pixel());
        drop_valid();
    endtask

    // Hold the output off for a long stretch while beats keep coming, so the
    // pipeline fills and pushes back on the input
    task automatic test_output_hold(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        @(negedge i_clk);
        hold_request = 1'b1;
        @(posedge i_clk);
        repeat (count) send_pixel(random_pixel());
        drop_valid();
    endtask

    // Send in small groups and let the pipeline drain empty between them
    task automatic test_drain_between_groups(input int groups);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (groups) begin
            repeat ($urandom_range(1, 12)) send_pixel(random_pixel());
            drop_valid();
            wait_drained();
        end
    endtask

    // Finish at full rate: no idling either side
    task automatic test_full_rate(input int count);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (count) send_pixel(random_pixel());
        drop_valid();
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_corner_colours();
        test_random_stream(400);
        test_output_hold(80);
        test_drain_between_groups(10);
        test_full_rate(100);

        wait_drained();
        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (hsv_due.size() != 0) mismatch_count++;

        $display("Converted %0d pixels, checked %0d results, %0d mismatches",
                 beats_in, beats_out, mismatch_count);
        $display("Input held off for %0d cycles across random and long output stalls",
                 input_stalls);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== rgb_to_hsv_converter.f =====
src/rhc_pkg.sv
src/rhc_front.sv
src/rhc_div_pipe.sv
src/rhc_back.sv
src/rgb_to_hsv_converter.sv
bench/tb_top.sv
